FILE: src/suspendable_inactivity_timeout_macros.svh
// ----------------------------------------------------------------------------
// Suspendable inactivity timeout assertion macros
// Clocked, reset-gated property helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef SUSPENDABLE_INACTIVITY_TIMEOUT_MACROS_SVH
`define SUSPENDABLE_INACTIVITY_TIMEOUT_MACROS_SVH

// same-cycle implication
`define SIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sit assertion failed: same-cycle check");

// next-cycle implication
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sit assertion failed: next-cycle check");

`endif

FILE: src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Types and constants shared by the suspendable inactivity timeout.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int OP_W        = 3;
  localparam int DELAY_W     = 24;
  localparam int ID_W        = 32;
  localparam int EVENT_W     = 2;
  localparam int SRC_IDX_W   = 4;
  localparam int STATE_W     = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_DIALOG  = 3'd3;
  localparam logic [OP_W-1:0] OP_SOURCE  = 3'd4;

  localparam logic [EVENT_W-1:0] EV_ACTIVATED   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_DEACTIVATED = 2'd1;
  localparam logic [EVENT_W-1:0] EV_INTERRUPT   = 2'd2;

  localparam logic [STATE_W-1:0] ST_NONE      = 3'd0;
  localparam logic [STATE_W-1:0] ST_ACTIVE    = 3'd1;
  localparam logic [STATE_W-1:0] ST_SUSPENDED = 3'd2;
  localparam logic [STATE_W-1:0] ST_STOPPED   = 3'd3;
  localparam logic [STATE_W-1:0] ST_FINISHED  = 3'd4;

  typedef enum logic [2:0] {
    K_NOP        = 3'd0,
    K_TICK       = 3'd1,
    K_REQUEST    = 3'd2,
    K_STOP       = 3'd3,
    K_DIALOG     = 3'd4,
    K_ACTIVATE   = 3'd5,
    K_DEACTIVATE = 3'd6,
    K_INTERRUPT  = 3'd7
  } kind_t;

  typedef enum logic [4:0] {
    PH_NONE      = 5'b00001,
    PH_ACTIVE    = 5'b00010,
    PH_SUSPENDED = 5'b00100,
    PH_STOPPED   = 5'b01000,
    PH_FINISHED  = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t                kind;
    logic [DELAY_W-1:0]   delay_ticks;
    logic [ID_W-1:0]      stop_id;
    logic                 dialog_idle;
    logic [SRC_IDX_W-1:0] source_index;
  } cmd_t;

  function automatic logic [STATE_W-1:0] phase_code(input phase_t ph);
    logic [STATE_W-1:0] code;
    case (ph)
      PH_NONE:      code = ST_NONE;
      PH_ACTIVE:    code = ST_ACTIVE;
      PH_SUSPENDED: code = ST_SUSPENDED;
      PH_STOPPED:   code = ST_STOPPED;
      PH_FINISHED:  code = ST_FINISHED;
      default:      code = ST_NONE;
    endcase
    return code;
  endfunction

endpackage

FILE: src/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Classifies an incoming request into a command kind for the back end.
// ----------------------------------------------------------------------------
module sit_front #(
  parameter int SOURCES = 16
) (
  input  logic [sit_pkg::OP_W-1:0]      in_operation,
  input  logic [sit_pkg::DELAY_W-1:0]   in_delay_ticks,
  input  logic [sit_pkg::ID_W-1:0]      in_stop_id,
  input  logic                          in_dialog_idle,
  input  logic [sit_pkg::EVENT_W-1:0]   in_source_event,
  input  logic [sit_pkg::SRC_IDX_W-1:0] in_source_index,
  output sit_pkg::cmd_t                 cmd
);
  import sit_pkg::*;

  logic  src_in_range;
  kind_t kind;

  assign src_in_range = (32'(in_source_index) < SOURCES);

  always_comb begin
    case (in_operation)
      OP_TICK:    kind = K_TICK;
      OP_REQUEST: kind = K_REQUEST;
      OP_STOP:    kind = K_STOP;
      OP_DIALOG:  kind = K_DIALOG;
      OP_SOURCE: begin
        if (!src_in_range) begin
          kind = K_NOP;
        end else begin
          case (in_source_event)
            EV_ACTIVATED:   kind = K_ACTIVATE;
            EV_DEACTIVATED: kind = K_DEACTIVATE;
            EV_INTERRUPT:   kind = K_INTERRUPT;
            default:        kind = K_NOP;
          endcase
        end
      end
      default:    kind = K_NOP;
    endcase
  end

  always_comb begin
    cmd.kind         = kind;
    cmd.delay_ticks  = in_delay_ticks;
    cmd.stop_id      = in_stop_id;
    cmd.dialog_idle  = in_dialog_idle;
    cmd.source_index = in_source_index;
  end

endmodule

FILE: src/sit_queue.sv
// ----------------------------------------------------------------------------
// sit_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sit_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_stall,
  input  sit_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_stall,
  output sit_pkg::cmd_t pop_cmd
);
  import sit_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/sit_back.sv
// ----------------------------------------------------------------------------
// sit_back
// Executes commands on the timeout state and registers one result each.
// ----------------------------------------------------------------------------
`include "suspendable_inactivity_timeout_macros.svh"

module sit_back #(
  parameter int SOURCES    = 16,
  parameter int DELAY_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  sit_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sit_pkg::ID_W-1:0]    out_issued_id,
  output logic                        out_stop_ok,
  output logic                        out_fired,
  output logic [sit_pkg::STATE_W-1:0] out_timeout_state
);
  import sit_pkg::*;

  logic [DELAY_BITS-1:0] remaining_r, remaining_nxt;
  logic [DELAY_BITS-1:0] loaded_r, loaded_nxt;
  phase_t                phase_r, phase_nxt;
  logic [ID_W-1:0]       current_id_r, current_id_nxt;
  logic [ID_W-1:0]       next_id_r, next_id_nxt;
  logic                  id_valid_r, id_valid_nxt;
  logic                  dialog_idle_r, dialog_idle_nxt;
  logic [SOURCES-1:0]    held_r, held_nxt;

  logic                  out_valid_r;
  logic [ID_W-1:0]       issued_id_r, issued_id_nxt;
  logic                  stop_ok_r, stop_ok_nxt;
  logic                  fired_r, fired_nxt;
  logic [STATE_W-1:0]    state_r;

  logic                        pop;
  logic [DELAY_BITS+DELAY_W-1:0] delay_wide;
  logic [DELAY_BITS-1:0]       delay_trunc;
  logic [SOURCES-1:0]          src_bit;
  logic [SOURCES-1:0]          held_cleared;

  assign pop       = cmd_valid && (!out_valid_r || !out_stall);
  assign cmd_stall = !pop;

  assign delay_wide   = {{DELAY_BITS{1'b0}}, cmd.delay_ticks};
  assign delay_trunc  = delay_wide[DELAY_BITS-1:0];
  assign held_cleared = held_r & ~src_bit;

  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      src_bit[i] = (32'(cmd.source_index) == i);
    end
  end

  always_comb begin
    remaining_nxt   = remaining_r;
    loaded_nxt      = loaded_r;
    phase_nxt       = phase_r;
    current_id_nxt  = current_id_r;
    next_id_nxt     = next_id_r;
    id_valid_nxt    = id_valid_r;
    dialog_idle_nxt = dialog_idle_r;
    held_nxt        = held_r;
    issued_id_nxt   = '0;
    stop_ok_nxt     = 1'b0;
    fired_nxt       = 1'b0;
    case (cmd.kind)
      K_TICK: begin
        if (phase_r == PH_ACTIVE) begin
          if (remaining_r <= DELAY_BITS'(1)) begin
            remaining_nxt = '0;
            fired_nxt     = 1'b1;
            phase_nxt     = PH_FINISHED;
          end else begin
            remaining_nxt = remaining_r - DELAY_BITS'(1);
          end
        end
      end
      K_REQUEST: begin
        held_nxt       = '0;
        loaded_nxt     = delay_trunc;
        current_id_nxt = next_id_r;
        next_id_nxt    = next_id_r + ID_W'(1);
        id_valid_nxt   = 1'b1;
        issued_id_nxt  = next_id_r;
        if (dialog_idle_r) begin
          remaining_nxt = delay_trunc;
          phase_nxt     = PH_ACTIVE;
        end else begin
          phase_nxt = PH_SUSPENDED;
        end
      end
      K_STOP: begin
        if (id_valid_r && (cmd.stop_id == current_id_r)) begin
          phase_nxt   = PH_STOPPED;
          stop_ok_nxt = 1'b1;
        end
      end
      K_DIALOG: begin
        dialog_idle_nxt = cmd.dialog_idle;
        if (cmd.dialog_idle && (held_r == '0)) begin
          if (phase_r == PH_SUSPENDED) begin
            remaining_nxt = loaded_r;
            phase_nxt     = PH_ACTIVE;
          end
        end else if (phase_r == PH_ACTIVE) begin
          phase_nxt = PH_SUSPENDED;
        end
      end
      K_ACTIVATE: begin
        held_nxt = held_r | src_bit;
        if (phase_r == PH_ACTIVE) begin
          phase_nxt = PH_SUSPENDED;
        end
      end
      K_DEACTIVATE: begin
        held_nxt = held_cleared;
        if (dialog_idle_r && (held_cleared == '0) && (phase_r == PH_SUSPENDED)) begin
          remaining_nxt = loaded_r;
          phase_nxt     = PH_ACTIVE;
        end
      end
      K_INTERRUPT: begin
        if (dialog_idle_r && (held_r == '0) && (phase_r == PH_SUSPENDED)) begin
          remaining_nxt = loaded_r;
          phase_nxt     = PH_ACTIVE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r   <= '0;
      loaded_r      <= '0;
      phase_r       <= PH_NONE;
      current_id_r  <= '0;
      next_id_r     <= '0;
      id_valid_r    <= 1'b0;
      dialog_idle_r <= 1'b1;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        remaining_r   <= remaining_nxt;
        loaded_r      <= loaded_nxt;
        phase_r       <= phase_nxt;
        current_id_r  <= current_id_nxt;
        next_id_r     <= next_id_nxt;
        id_valid_r    <= id_valid_nxt;
        dialog_idle_r <= dialog_idle_nxt;
        held_r        <= held_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      issued_id_r <= issued_id_nxt;
      stop_ok_r   <= stop_ok_nxt;
      fired_r     <= fired_nxt;
      state_r     <= phase_code(phase_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_issued_id     = issued_id_r;
  assign out_stop_ok       = stop_ok_r;
  assign out_fired         = fired_r;
  assign out_timeout_state = state_r;

  `SIT_ASSERT_NOW(a_active_is_free, phase_r == PH_ACTIVE, dialog_idle_r && (held_r == '0))
  `SIT_ASSERT_NEXT(a_expire_fires, pop && (cmd.kind == K_TICK) && (phase_r == PH_ACTIVE) && (remaining_r <= DELAY_BITS'(1)), (phase_r == PH_FINISHED) && fired_r && out_valid_r)
  `SIT_ASSERT_NEXT(a_request_clears, pop && (cmd.kind == K_REQUEST), (held_r == '0) && id_valid_r && (issued_id_r == current_id_r))
  `SIT_ASSERT_NEXT(a_stop_match, pop && (cmd.kind == K_STOP) && id_valid_r && (cmd.stop_id == current_id_r), (phase_r == PH_STOPPED) && stop_ok_r)

endmodule

FILE: src/suspendable_inactivity_timeout.sv
// ----------------------------------------------------------------------------
// suspendable_inactivity_timeout
// One-shot inactivity timeout that suspends while the dialog is busy or an
// activity source is held.
// ----------------------------------------------------------------------------
// channel  direction  handshake         payload
// in_      input      in_valid/in_stall operation, delay, stop id, dialog, source
// out_     output     out_valid/stall   issued id, stop ok, fired, timeout state
//
// One request per cycle while the output is not stalled; a result is valid once
// the request has passed the queue and been executed into the output register.
// The back end updates all timeout state once per request.
// Synchronous active-low reset clears control and timeout state; the dialog starts idle.
// A stalled output holds the back end; the two-entry queue absorbs the slip.
// ----------------------------------------------------------------------------
module suspendable_inactivity_timeout #(
  parameter int SOURCES    = 16,
  parameter int DELAY_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sit_pkg::OP_W-1:0]      in_operation,
  input  logic [sit_pkg::DELAY_W-1:0]   in_delay_ticks,
  input  logic [sit_pkg::ID_W-1:0]      in_stop_id,
  input  logic                          in_dialog_idle,
  input  logic [sit_pkg::EVENT_W-1:0]   in_source_event,
  input  logic [sit_pkg::SRC_IDX_W-1:0] in_source_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sit_pkg::ID_W-1:0]      out_issued_id,
  output logic                          out_stop_ok,
  output logic                          out_fired,
  output logic [sit_pkg::STATE_W-1:0]   out_timeout_state
);
  import sit_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_stall;

  sit_front #(
    .SOURCES (SOURCES)
  ) u_front (
    .in_operation    (in_operation),
    .in_delay_ticks  (in_delay_ticks),
    .in_stop_id      (in_stop_id),
    .in_dialog_idle  (in_dialog_idle),
    .in_source_event (in_source_event),
    .in_source_index (in_source_index),
    .cmd             (front_cmd)
  );

  sit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_cmd    (q_cmd)
  );

  sit_back #(
    .SOURCES    (SOURCES),
    .DELAY_BITS (DELAY_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd_stall         (q_stall),
    .cmd               (q_cmd),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_issued_id     (out_issued_id),
    .out_stop_ok       (out_stop_ok),
    .out_fired         (out_fired),
    .out_timeout_state (out_timeout_state)
  );

endmodule
